// ===== sv/pac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_pkg
// Shared types and constants for the polynomial arccos / arcsin pipeline.
// ----------------------------------------------------------------------------
package pac_pkg;

  localparam int XW       = 17;   // Q1.16 argument, 65536 = 1.0
  localparam int ANGLE_W  = 17;   // Q1.16 angle
  localparam int ACC_W    = 32;   // Q2.30 Horner accumulator
  localparam int ROOT_W   = 36;   // square-root remainder and root
  localparam int PROD_W   = 49;   // accumulator times root
  localparam int NUM_CELLS  = 9;  // two root digits per cell
  localparam int NUM_HORNER = 7;  // Horner steps, one per cell

  localparam logic [XW-1:0]      ONE_Q16     = 17'd65536;
  localparam logic [ANGLE_W-1:0] HALF_PI_Q16 = 17'd102944;

  // Coefficients c0..c7 in Q2.30, c0 first
  localparam logic signed [ACC_W-1:0] COEF [NUM_HORNER+1] = '{
    32'sd1686629690,
    -32'sd230423709,
    32'sd95540460,
    -32'sd53874249,
    32'sd33169905,
    -32'sd18348235,
    32'sd7161955,
    -32'sd1355589
  };

  typedef struct packed {
    logic                     act;
    logic [XW-1:0]            x;
    logic signed [ACC_W-1:0]  acc;
    logic [ROOT_W-1:0]        rem;
    logic [ROOT_W-1:0]        root;
  } cell_t;

endpackage

// ===== sv/poly_arccos_arcsin.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly_arccos_arcsin
// Fixed-point arccos / arcsin of an argument in [0,1], polynomial times root.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_ready carry in_action (0 arccos, 1 arcsin) and
// in_x_value, unsigned Q1.16 with 65536 = 1.0; larger codes count as 1.0.
// Output channel: out_valid / out_ready carry out_angle, radians in unsigned
// Q1.16, 0..102944 (pi/2).
// A row of nine cells each performs one Horner step of the degree-7
// polynomial (first seven cells) and two digits of the restoring square root
// of 1 - x; two further stages form the product, round, clamp and subtract
// for arcsin. Throughput is one transaction per cycle while out_ready stays
// high; every stage is a register with its own valid bit, so a new argument
// enters each cycle while results flow.
// When the receiver holds out_ready low the stages fill up one by one and
// in_ready falls only once all eleven are occupied; bubbles are squeezed out.
// Reset (synchronous, rst_n low) empties every stage; no result is pending
// afterwards and the block keeps no other state.
// ----------------------------------------------------------------------------
module poly_arccos_arcsin (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [pac_pkg::XW-1:0]        in_x_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pac_pkg::ANGLE_W-1:0]   out_angle
);

  pac_pkg::cell_t             chain_data  [pac_pkg::NUM_CELLS+1];
  logic                       chain_valid [pac_pkg::NUM_CELLS+1];
  logic                       chain_ready [pac_pkg::NUM_CELLS+1];
  logic [pac_pkg::XW-1:0]     x_sat;

  // Saturate the argument to one and seed the chain
  assign x_sat = (in_x_value > pac_pkg::ONE_Q16) ? pac_pkg::ONE_Q16 : in_x_value;

  always_comb begin
    chain_data[0].act  = in_action;
    chain_data[0].x    = x_sat;
    chain_data[0].acc  = pac_pkg::COEF[pac_pkg::NUM_HORNER];
    chain_data[0].rem  = {3'b000, pac_pkg::ONE_Q16 - x_sat, 16'h0000};
    chain_data[0].root = '0;
  end

  assign chain_valid[0] = in_valid;
  assign in_ready       = chain_ready[0];

  for (genvar g = 0; g < pac_pkg::NUM_CELLS; g++) begin : g_cell
    localparam int CoefIdx = (g < pac_pkg::NUM_HORNER) ? (pac_pkg::NUM_HORNER - 1 - g) : 0;
    localparam logic [pac_pkg::ROOT_W-1:0] BitHi =
      36'd1 << (2 * (2 * pac_pkg::NUM_CELLS - 1) - 4 * g);

    pac_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .horner_en ((g < pac_pkg::NUM_HORNER) ? 1'b1 : 1'b0),
      .coef      (pac_pkg::COEF[CoefIdx]),
      .bit_hi    (BitHi),
      .in_valid  (chain_valid[g]),
      .in_ready  (chain_ready[g]),
      .in_data   (chain_data[g]),
      .out_valid (chain_valid[g+1]),
      .out_ready (chain_ready[g+1]),
      .out_data  (chain_data[g+1])
    );
  end

  pac_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chain_valid[pac_pkg::NUM_CELLS]),
    .in_ready  (chain_ready[pac_pkg::NUM_CELLS]),
    .in_data   (chain_data[pac_pkg::NUM_CELLS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_angle (out_angle)
  );

endmodule

// ===== sv/pac_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_cell
// One pipeline cell: an optional Horner step and two square-root digits.
// ----------------------------------------------------------------------------
module pac_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            horner_en,
  input  logic signed [pac_pkg::ACC_W-1:0] coef,
  input  logic [pac_pkg::ROOT_W-1:0]      bit_hi,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pac_pkg::cell_t                  in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pac_pkg::cell_t                  out_data
);

  logic           valid_r;
  logic           valid_nxt;
  pac_pkg::cell_t data_r;
  pac_pkg::cell_t data_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_comb begin
    logic signed [pac_pkg::ACC_W+pac_pkg::XW:0] prod;
    logic signed [pac_pkg::ACC_W+pac_pkg::XW:0] rnd;
    logic [pac_pkg::ROOT_W-1:0]                 bit_lo;
    logic [pac_pkg::ROOT_W-1:0]                 rem;
    logic [pac_pkg::ROOT_W-1:0]                 root;
    logic [pac_pkg::ROOT_W-1:0]                 trial;

    data_nxt = in_data;

    // Horner: acc = round(acc * x / 2^16) + c, ties upward
    prod = in_data.acc * $signed({1'b0, in_data.x});
    rnd  = (prod + 50'sd32768) >>> 16;
    if (horner_en) begin
      data_nxt.acc = $signed(rnd[pac_pkg::ACC_W-1:0]) + coef;
    end

    // Two restoring square-root digits
    bit_lo = bit_hi >> 2;
    rem    = in_data.rem;
    root   = in_data.root;
    trial  = root + bit_hi;
    if (rem >= trial) begin
      rem  = rem - trial;
      root = (root >> 1) + bit_hi;
    end else begin
      root = root >> 1;
    end
    trial = root + bit_lo;
    if (rem >= trial) begin
      rem  = rem - trial;
      root = (root >> 1) + bit_lo;
    end else begin
      root = root >> 1;
    end
    data_nxt.rem  = rem;
    data_nxt.root = root;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== sv/pac_post.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_post
// Final product with the root, rounding, clamp and arcsin selection.
// ----------------------------------------------------------------------------
module pac_post (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pac_pkg::cell_t                    in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pac_pkg::ANGLE_W-1:0]       out_angle
);

  // Product stage
  logic                        va_r;
  logic                        va_nxt;
  logic                        act_a_r;
  logic                        nonpos_a_r;
  logic [pac_pkg::PROD_W-1:0]  prod_a_r;
  logic [pac_pkg::PROD_W-1:0]  prod_a_nxt;
  logic                        ready_b;

  // Output stage
  logic                        vb_r;
  logic                        vb_nxt;
  logic [pac_pkg::ANGLE_W-1:0] angle_r;
  logic [pac_pkg::ANGLE_W-1:0] angle_nxt;

  assign ready_b  = !vb_r || out_ready;
  assign in_ready = !va_r || ready_b;
  assign va_nxt   = in_ready ? in_valid : va_r;
  assign vb_nxt   = ready_b ? va_r : vb_r;

  assign prod_a_nxt = in_data.acc * in_data.root[pac_pkg::XW-1:0];

  always_comb begin
    logic [pac_pkg::PROD_W:0]    sum;
    logic [pac_pkg::ANGLE_W+1:0] acos_w;
    logic [pac_pkg::ANGLE_W-1:0] acos_v;

    sum    = {1'b0, prod_a_r} + 50'd536870912;
    acos_w = sum[pac_pkg::PROD_W-1:30];
    if (nonpos_a_r) begin
      acos_v = '0;
    end else if (acos_w > {2'b00, pac_pkg::HALF_PI_Q16}) begin
      acos_v = pac_pkg::HALF_PI_Q16;
    end else begin
      acos_v = acos_w[pac_pkg::ANGLE_W-1:0];
    end
    angle_nxt = act_a_r ? (pac_pkg::HALF_PI_Q16 - acos_v) : acos_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_a_r    <= in_data.act;
      nonpos_a_r <= (in_data.acc <= 0);
      prod_a_r   <= prod_a_nxt;
    end
    if (va_r && ready_b) begin
      angle_r <= angle_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_angle = angle_r;

  // Result never leaves [0, pi/2]
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r |-> (angle_r <= pac_pkg::HALF_PI_Q16))
    else $error("angle above pi/2");

  // A product held while the output stage is blocked is not dropped
  a_prod_held: assert property (@(posedge clk) disable iff (!rst_n)
    (va_r && !ready_b) |=> (va_r && $stable(prod_a_r)))
    else $error("product stage lost a transaction");

  // Reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> (!va_r && !vb_r))
    else $error("stage valid after reset");

endmodule
